>>> hw/rtl/u2c_pkg.sv
// ----------------------------------------------------------------------------
// u2c_pkg
// Shared types, the CP1251 upper-half table and the code unit mapping.
// ----------------------------------------------------------------------------
`default_nettype none

package u2c_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned UnitW = 16;
  localparam int unsigned PendW = 2;
  localparam int unsigned TableDepth = 128;

  localparam logic [ByteW-1:0] QMark = 8'h3F;
  localparam logic [ByteW-1:0] HighBase = 8'h80;

  // decoder state: continuation bytes still expected and the unit so far
  typedef struct packed {
    logic [PendW-1:0] pend;
    logic [UnitW-1:0] acc;
  } u2c_state_t;

  // Unicode code unit for CP1251 bytes 0x80..0xFF
  localparam logic [UnitW-1:0] UpperHalf [TableDepth] = '{
    16'h0402, 16'h0403, 16'h201A, 16'h0453, 16'h201E, 16'h2026, 16'h2020, 16'h2021,
    16'h20AC, 16'h2030, 16'h0409, 16'h2039, 16'h040A, 16'h040C, 16'h040B, 16'h040F,
    16'h0452, 16'h2018, 16'h2019, 16'h201C, 16'h201D, 16'h2022, 16'h2013, 16'h2014,
    16'h0098, 16'h2122, 16'h0459, 16'h203A, 16'h045A, 16'h045C, 16'h045B, 16'h045F,
    16'h00A0, 16'h040E, 16'h045E, 16'h0408, 16'h00A4, 16'h0490, 16'h00A6, 16'h00A7,
    16'h0401, 16'h00A9, 16'h0404, 16'h00AB, 16'h00AC, 16'h00AD, 16'h00AE, 16'h0407,
    16'h00B0, 16'h00B1, 16'h0406, 16'h0456, 16'h0491, 16'h00B5, 16'h00B6, 16'h00B7,
    16'h0451, 16'h2116, 16'h0454, 16'h00BB, 16'h0458, 16'h0405, 16'h0455, 16'h0457,
    16'h0410, 16'h0411, 16'h0412, 16'h0413, 16'h0414, 16'h0415, 16'h0416, 16'h0417,
    16'h0418, 16'h0419, 16'h041A, 16'h041B, 16'h041C, 16'h041D, 16'h041E, 16'h041F,
    16'h0420, 16'h0421, 16'h0422, 16'h0423, 16'h0424, 16'h0425, 16'h0426, 16'h0427,
    16'h0428, 16'h0429, 16'h042A, 16'h042B, 16'h042C, 16'h042D, 16'h042E, 16'h042F,
    16'h0430, 16'h0431, 16'h0432, 16'h0433, 16'h0434, 16'h0435, 16'h0436, 16'h0437,
    16'h0438, 16'h0439, 16'h043A, 16'h043B, 16'h043C, 16'h043D, 16'h043E, 16'h043F,
    16'h0440, 16'h0441, 16'h0442, 16'h0443, 16'h0444, 16'h0445, 16'h0446, 16'h0447,
    16'h0448, 16'h0449, 16'h044A, 16'h044B, 16'h044C, 16'h044D, 16'h044E, 16'h044F
  };

  // unit -> CP1251 byte; table hit wins, ASCII passes, else '?'
  function automatic logic [ByteW-1:0] map_unit(input logic [UnitW-1:0] unit);
    logic [ByteW-1:0] res;
    res = QMark;
    if (unit < UnitW'(HighBase)) res = unit[ByteW-1:0];
    for (int i = 0; i < TableDepth; i++) begin
      if (UpperHalf[i] == unit) res = HighBase | ByteW'(i);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/u2c_decode.sv
// ----------------------------------------------------------------------------
// u2c_decode
// UTF-8 step logic: next decoder state, emit flag and emitted code unit.
// ----------------------------------------------------------------------------
`default_nettype none

module u2c_decode
  import u2c_pkg::*;
(
  input  wire logic [ByteW-1:0] byte_i,
  input  wire logic             last_i,
  input  wire u2c_state_t       state_i,
  output u2c_state_t            state_o,
  output logic                  emit_o,
  output logic [UnitW-1:0]      unit_o
);

  u2c_state_t nxt;
  logic       emit;

  always_comb begin
    nxt  = state_i;
    emit = 1'b0;
    if (state_i.pend != '0) begin
      if (state_i.pend[1]) begin
        // first continuation (a count of 3 behaves as 2)
        nxt.acc  = state_i.acc | {4'b0, byte_i[5:0], 6'b0};
        nxt.pend = PendW'(1);
      end else begin
        nxt.acc  = state_i.acc | {10'b0, byte_i[5:0]};
        nxt.pend = '0;
        emit     = 1'b1;
      end
    end else if (!byte_i[7]) begin
      nxt.acc = {8'b0, byte_i};
      emit    = 1'b1;
    end else if (byte_i[7:5] == 3'b110) begin
      nxt.acc  = {5'b0, byte_i[4:0], 6'b0};
      nxt.pend = PendW'(1);
    end else if (byte_i[7:4] == 4'b1110) begin
      nxt.acc  = {byte_i[3:0], 12'b0};
      nxt.pend = PendW'(2);
    end else begin
      // stray continuation or 4-byte lead: repeat last unit
      emit = 1'b1;
    end
  end

  assign emit_o  = emit | last_i;
  assign unit_o  = nxt.acc;
  assign state_o = last_i ? '0 : nxt;

endmodule

`default_nettype wire

>>> hw/rtl/utf8_to_cp1251_transcoder.sv
// ----------------------------------------------------------------------------
// utf8_to_cp1251_transcoder
// UTF-8 byte stream to Windows-1251 byte stream, with the decoded code unit.
// ----------------------------------------------------------------------------
// Takes one UTF-8 byte per beat and returns one CP1251 byte for each complete
// one-, two- or three-byte sequence, together with the 16-bit code unit it came
// from. tlast on the input marks the final byte of a string: that beat always
// yields a result (a partial unit if a sequence is cut short) carrying tlast,
// and the decoder then clears. Continuation bytes are not checked. A stray
// continuation byte or a four-byte lead repeats the previous unit (0 at the
// start of a string). Units not in the CP1251 table and not ASCII map to '?'.
// Throughput is one byte per clock while the output accepts. The result is
// registered once after the UTF-8 decode step and once after the
// 128-entry table match. Backpressure stalls the stages in place; each stage
// refills in the cycle it drains, so no bubbles are added.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_to_cp1251_transcoder
  import u2c_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // slave side
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  wire logic        s_axis_tlast,   // string_end
  // master side
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,   // [7:0] out_byte, [23:8] code_unit
  output logic             m_axis_tlast    // string_end_out
);

  // decoder state
  u2c_state_t       state_q, state_d;
  // stage 1: decoded unit awaiting mapping
  logic             s1_vld_q, s1_vld_d;
  logic [UnitW-1:0] s1_unit_q;
  logic             s1_last_q;
  // stage 2: output register
  logic             out_vld_q, out_vld_d;
  logic [ByteW-1:0] out_byte_q;
  logic [UnitW-1:0] out_unit_q;
  logic             out_last_q;

  logic             in_beat;
  logic             s1_rdy, s2_rdy;
  logic             dec_emit;
  logic [UnitW-1:0] dec_unit;

  u2c_decode u_decode (
    .byte_i  (s_axis_tdata),
    .last_i  (s_axis_tlast),
    .state_i (state_q),
    .state_o (state_d),
    .emit_o  (dec_emit),
    .unit_o  (dec_unit)
  );

  // ready ripples back: a stage may load when empty or draining this cycle
  assign s2_rdy        = !out_vld_q || m_axis_tready;
  assign s1_rdy        = !s1_vld_q || s2_rdy;
  assign s_axis_tready = s1_rdy;
  assign in_beat       = s_axis_tvalid && s1_rdy;

  always_comb begin
    if (in_beat) begin
      s1_vld_d = dec_emit;
    end else if (s2_rdy) begin
      s1_vld_d = 1'b0;
    end else begin
      s1_vld_d = s1_vld_q;
    end
    out_vld_d = s2_rdy ? s1_vld_q : out_vld_q;
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= '0;
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_beat) state_q <= state_d;
      s1_vld_q  <= s1_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (in_beat && dec_emit) begin
      s1_unit_q <= dec_unit;
      s1_last_q <= s_axis_tlast;
    end
    if (s2_rdy && s1_vld_q) begin
      out_byte_q <= map_unit(s1_unit_q);
      out_unit_q <= s1_unit_q;
      out_last_q <= s1_last_q;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {out_unit_q, out_byte_q};
  assign m_axis_tlast  = out_last_q;

endmodule

`default_nettype wire

>>> test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the UTF-8 to CP1251 transcoder.
// ----------------------------------------------------------------------------
// Feeds UTF-8 strings one byte per beat and predicts every CP1251 beat that
// should come back: the mapped byte, the decoded unit and the string end flag.
// Covers a directed set of corner cases first, then random text that is
// mostly well formed with noise, broken continuations and cut-off endings.
// The sender runs in bursts with gaps, the receiver stalls on its own
// schedule, and one long receiver hold-off makes the block back up.
// ----------------------------------------------------------------------------

module tb;

  localparam int WatchdogLimit = 4000;  // idle cycles before giving up
  localparam int DrainCycles   = 8;     // two-stage pipe plus margin
  localparam int MaxReported   = 10;

  localparam logic [7:0] QMark = 8'h3F;

  // CP1251 0x80..0xFF as Unicode units, entry i at bits (127-i)*16
  localparam logic [128*16-1:0] Cp1251Upper = {
    16'h0402, 16'h0403, 16'h201A, 16'h0453, 16'h201E, 16'h2026, 16'h2020, 16'h2021,
    16'h20AC, 16'h2030, 16'h0409, 16'h2039, 16'h040A, 16'h040C, 16'h040B, 16'h040F,
    16'h0452, 16'h2018, 16'h2019, 16'h201C, 16'h201D, 16'h2022, 16'h2013, 16'h2014,
    16'h0098, 16'h2122, 16'h0459, 16'h203A, 16'h045A, 16'h045C, 16'h045B, 16'h045F,
    16'h00A0, 16'h040E, 16'h045E, 16'h0408, 16'h00A4, 16'h0490, 16'h00A6, 16'h00A7,
    16'h0401, 16'h00A9, 16'h0404, 16'h00AB, 16'h00AC, 16'h00AD, 16'h00AE, 16'h0407,
    16'h00B0, 16'h00B1, 16'h0406, 16'h0456, 16'h0491, 16'h00B5, 16'h00B6, 16'h00B7,
    16'h0451, 16'h2116, 16'h0454, 16'h00BB, 16'h0458, 16'h0405, 16'h0455, 16'h0457,
    16'h0410, 16'h0411, 16'h0412, 16'h0413, 16'h0414, 16'h0415, 16'h0416, 16'h0417,
    16'h0418, 16'h0419, 16'h041A, 16'h041B, 16'h041C, 16'h041D, 16'h041E, 16'h041F,
    16'h0420, 16'h0421, 16'h0422, 16'h0423, 16'h0424, 16'h0425, 16'h0426, 16'h0427,
    16'h0428, 16'h0429, 16'h042A, 16'h042B, 16'h042C, 16'h042D, 16'h042E, 16'h042F,
    16'h0430, 16'h0431, 16'h0432, 16'h0433, 16'h0434, 16'h0435, 16'h0436, 16'h0437,
    16'h0438, 16'h0439, 16'h043A, 16'h043B, 16'h043C, 16'h043D, 16'h043E, 16'h043F,
    16'h0440, 16'h0441, 16'h0442, 16'h0443, 16'h0444, 16'h0445, 16'h0446, 16'h0447,
    16'h0448, 16'h0449, 16'h044A, 16'h044B, 16'h044C, 16'h044D, 16'h044E, 16'h044F
  };

  // one output beat as the block should present it
  typedef struct packed {
    logic [7:0]  cp;
    logic [15:0] unit;
    logic        last;
  } cp1251_beat_t;

  // receiver stall schedules
  typedef enum logic [1:0] {
    RxAlways,
    RxCoin,
    RxMostly,
    RxOneInFour
  } rx_mode_e;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] in_byte
  logic        s_axis_tlast;   // string_end
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;   // [7:0] out_byte, [23:8] code_unit
  logic        m_axis_tlast;   // string_end_out

  utf8_to_cp1251_transcoder dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  // predicted beats still on their way out
  cp1251_beat_t cp1251_due_q[$];

  // decoder shadow state
  logic [1:0]  dec_pend;
  logic [15:0] dec_acc;

  // bytes of the string being built
  logic [7:0]  text_q[$];

  int burst_left;
  int rx_hold_cycles;
  int rx_run;
  rx_mode_e rx_mode;
  int idle_cycles;
  int mismatches;
  int n_sent;
  int n_strings;
  int n_checked;

  cp1251_beat_t got_beat;
  cp1251_beat_t want_beat;

  // 2 ns clock
  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic logic [7:0] cp1251_of(input logic [15:0] unit);
    logic [7:0] res;
    res = (unit < 16'h0080) ? unit[7:0] : QMark;
    for (int i = 0; i < 128; i++) begin
      if (Cp1251Upper[(127-i)*16 +: 16] == unit) res = 8'h80 | 8'(i);
    end
    return res;
  endfunction

  // Advances the shadow decoder by one accepted byte and queues the beat it
  // yields, if any. The string end beat always yields, then clears state.
  task automatic predict_cp1251(input logic [7:0] b, input logic last);
    logic emit;
    cp1251_beat_t beat;
    emit = 1'b0;
    if (dec_pend != 2'd0) begin
      // continuation: top bits are not checked
      if (dec_pend >= 2'd2) begin
        dec_acc  = dec_acc | {4'b0, b[5:0], 6'b0};
        dec_pend = 2'd1;
      end else begin
        dec_acc  = dec_acc | {10'b0, b[5:0]};
        dec_pend = 2'd0;
        emit     = 1'b1;
      end
    end else if (b[7] == 1'b0) begin
      dec_acc = {8'b0, b};
      emit    = 1'b1;
    end else if (b[7:5] == 3'b110) begin
      dec_acc  = {5'b0, b[4:0], 6'b0};
      dec_pend = 2'd1;
    end else if (b[7:4] == 4'b1110) begin
      dec_acc  = {b[3:0], 12'b0};
      dec_pend = 2'd2;
    end else begin
      // stray continuation or four-byte lead: repeat the last unit
      emit = 1'b1;
    end
    if (last) emit = 1'b1;
    if (emit) begin
      beat.cp   = cp1251_of(dec_acc);
      beat.unit = dec_acc;
      beat.last = last;
      cp1251_due_q.insert(cp1251_due_q.size(), beat);
    end
    if (last) begin
      dec_pend = 2'd0;
      dec_acc  = 16'h0000;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sender: bursts of beats with random gaps in between
  // ---------------------------------------------------------------------------

  // Called and returns at a falling edge. Valid stays high across a burst.
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_cp1251(b, last);
    n_sent++;
    burst_left--;
    @(negedge clk_i);
  endtask

  task automatic push_utf8(input logic [15:0] unit);
    if (unit < 16'h0080) begin
      text_q.insert(text_q.size(), unit[7:0]);
    end else if (unit < 16'h0800) begin
      text_q.insert(text_q.size(), {3'b110, unit[10:6]});
      text_q.insert(text_q.size(), {2'b10, unit[5:0]});
    end else begin
      text_q.insert(text_q.size(), {4'b1110, unit[15:12]});
      text_q.insert(text_q.size(), {2'b10, unit[11:6]});
      text_q.insert(text_q.size(), {2'b10, unit[5:0]});
    end
  endtask

  // One string of mostly valid text; tlast rides on its final byte.
  task automatic send_random_string();
    int n_chars;
    int kind;
    int start;
    text_q.delete();
    n_chars = $urandom_range(1, 12);
    for (int c = 0; c < n_chars; c++) begin
      kind  = $urandom_range(0, 99);
      start = text_q.size();
      if (kind < 35) begin
        text_q.insert(text_q.size(), 8'($urandom_range(0, 127)));
      end else if (kind < 60) begin
        // something CP1251 can represent
        push_utf8(Cp1251Upper[(127 - $urandom_range(0, 127))*16 +: 16]);
      end else if (kind < 75) begin
        push_utf8(16'($urandom_range(16'h0080, 16'hFFFF)));
      end else if (kind < 85) begin
        // proper lead, garbage continuations
        push_utf8(16'($urandom_range(16'h0080, 16'hFFFF)));
        for (int k = start + 1; k < text_q.size(); k++) text_q[k] = 8'($urandom);
      end else if (kind < 93) begin
        text_q.insert(text_q.size(), 8'($urandom));
      end else begin
        // sequence missing its last byte; the next byte completes it
        push_utf8(16'($urandom_range(16'h0080, 16'hFFFF)));
        text_q = text_q[0:$-1];
      end
    end
    // sometimes the string ends in the middle of a sequence
    if (text_q.size() > 1 && $urandom_range(0, 6) == 0) text_q = text_q[0:$-1];
    for (int k = 0; k < text_q.size(); k++) send_byte(text_q[k], k == text_q.size() - 1);
    n_strings++;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: stall schedule changes every so often; a hold-off request from
  // a test task overrides it and is counted down here
  // ---------------------------------------------------------------------------

  always @(negedge clk_i) begin
    if (rx_hold_cycles > 0) begin
      m_axis_tready <= 1'b0;
      rx_hold_cycles = rx_hold_cycles - 1;
    end else begin
      if (rx_run == 0) begin
        rx_mode = rx_mode_e'($urandom_range(0, 3));
        rx_run  = $urandom_range(16, 160);
      end
      rx_run = rx_run - 1;
      case (rx_mode)
        RxAlways:    m_axis_tready <= 1'b1;
        RxCoin:      m_axis_tready <= 1'($urandom_range(0, 1));
        RxMostly:    m_axis_tready <= ($urandom_range(0, 9) != 0);
        RxOneInFour: m_axis_tready <= (rx_run[1:0] == 2'd0);
        default:     m_axis_tready <= 1'b1;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Checker: every output beat against the oldest prediction
  // ---------------------------------------------------------------------------

  task automatic note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MaxReported) $display("%t mismatch: %s", $realtime, msg);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_beat.cp   = m_axis_tdata[7:0];
      got_beat.unit = m_axis_tdata[23:8];
      got_beat.last = m_axis_tlast;
      n_checked++;
      if (cp1251_due_q.size() == 0) begin
        note_mismatch($sformatf("unexpected beat byte %02h unit %04h last %0b",
                                got_beat.cp, got_beat.unit, got_beat.last));
      end else begin
        want_beat = cp1251_due_q.pop_front();
        if (got_beat.cp != want_beat.cp || got_beat.unit != want_beat.unit ||
            got_beat.last != want_beat.last) begin
          note_mismatch($sformatf(
            "expected byte %02h unit %04h last %0b, got byte %02h unit %04h last %0b",
            want_beat.cp, want_beat.unit, want_beat.last,
            got_beat.cp, got_beat.unit, got_beat.last));
        end
      end
    end
  end

  // Watchdog: a run of cycles with no beat moving on either side means a hang.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles = 0;
    else
      idle_cycles = idle_cycles + 1;
    if (idle_cycles == WatchdogLimit) begin
      $display("watchdog: no beat moved for %0d cycles", WatchdogLimit);
      $display("tb: failure");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Corner cases straight after reset, while the unit register is still 0.
  task automatic test_directed();
    send_byte(8'h80, 1'b1);                          // stray byte at string start
    send_byte(8'h61, 1'b0);                          // plain ASCII
    send_byte(8'h00, 1'b0);                          // lowest byte
    send_byte(8'h7F, 1'b0);                          // highest ASCII
    send_byte(8'hD0, 1'b0); send_byte(8'h90, 1'b0);  // Cyrillic A, 0xC0
    send_byte(8'hD1, 1'b0); send_byte(8'h8F, 1'b0);  // last table entry, 0xFF
    send_byte(8'hE2, 1'b0); send_byte(8'h82, 1'b0);  // euro sign, three bytes
    send_byte(8'hAC, 1'b0);
    send_byte(8'hE4, 1'b0); send_byte(8'hB8, 1'b0);  // CJK unit, maps to '?'
    send_byte(8'h80, 1'b0);
    send_byte(8'hBF, 1'b0);                          // stray: repeats last unit
    send_byte(8'hF0, 1'b0);                          // four-byte lead: repeats
    send_byte(8'hC2, 1'b0); send_byte(8'h98, 1'b0);  // table entry below 0x100
    send_byte(8'hC3, 1'b0); send_byte(8'h41, 1'b0);  // continuation not 10xxxxxx
    send_byte(8'hE0, 1'b0); send_byte(8'h80, 1'b1);  // end after one continuation
    send_byte(8'hDF, 1'b1);                          // end right after a lead
    send_byte(8'hFF, 1'b1);                          // top byte alone
    send_byte(8'hEF, 1'b1);                          // top three-byte lead, cut off
  endtask

  task automatic test_random_text(input int n_bytes);
    int stop_at;
    stop_at = n_sent + n_bytes;
    while (n_sent < stop_at) send_random_string();
  endtask

  // Receiver holds off while the sender keeps offering; the input must stall.
  task automatic test_output_stall();
    rx_hold_cycles = 300;
    test_random_text(60);
  endtask

  // Sender goes quiet until every predicted beat is out, then resumes.
  task automatic test_drain_pause();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    do @(negedge clk_i); while (cp1251_due_q.size() != 0);
    test_random_text(40);
  endtask

  initial begin
    rst_ni         = 1'b0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = 8'h00;
    s_axis_tlast   = 1'b0;
    m_axis_tready  = 1'b0;
    dec_pend       = 2'd0;
    dec_acc        = 16'h0000;
    burst_left     = 0;
    rx_hold_cycles = 0;
    rx_run         = 0;
    rx_mode        = RxAlways;
    idle_cycles    = 0;
    mismatches     = 0;
    n_sent         = 0;
    n_strings      = 0;
    n_checked      = 0;

    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed();
    test_random_text(850);
    test_output_stall();
    test_drain_pause();
    test_random_text(900);

    // let the pipe empty, then watch for stray beats
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (cp1251_due_q.size() != 0);
    repeat (DrainCycles) @(negedge clk_i);

    $display("summary: %0d bytes in %0d strings, %0d output beats checked, %0d mismatches",
             n_sent, n_strings, n_checked, mismatches);
    $display("summary: corner cases, random and broken UTF-8, long output stall, full drain");
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/u2c_pkg.sv
hw/rtl/u2c_decode.sv
hw/rtl/utf8_to_cp1251_transcoder.sv
test/tb.sv
